// File: hw/rtl/kpc_pkg.sv
// Package for the key press classifier: item types, event codes and register indexes.
`default_nettype none

package kpc_pkg;

	// Width of the configuration register index and of its data.
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_CODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [7:0]  IDLE_CODE_RST  = 8'd0;
	localparam logic [31:0] LONG_TICKS_RST = 32'd1000;

	// Event codes.
	typedef logic [1:0] event_kind_t;
	localparam event_kind_t EV_NONE  = 2'd0;
	localparam event_kind_t EV_PRESS = 2'd1;
	localparam event_kind_t EV_SHORT = 2'd2;
	localparam event_kind_t EV_LONG  = 2'd3;

	// One keypad poll.
	typedef struct packed {
		logic [7:0]  key_now;
		logic [31:0] time_now;
	} in_item_t;

	// One classified poll.
	typedef struct packed {
		logic [7:0]  key_out;
		event_kind_t event_kind;
		logic        repeat_active;
	} out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/key_press_classifier.sv
// Key press classifier: turns keypad polls into press, short release and long press events.
`default_nettype none

// Each accepted item is one keypad poll (key code and millisecond timestamp) and
// yields exactly one result item, held first in the input register and then in
// the result register: the key code concerned, the event (none or held, press,
// short release, long press) and the repeat flag.
// The block accepts one item per clock cycle while the result channel does not stall;
// the figure is set by the single compare-and-subtract pass between the input register
// and the result register, which also updates the key history in that same cycle.
// The idle code and long-press threshold must be written through the configuration port
// while no item is in flight (not enforced by the block); they apply to the next item.
module key_press_classifier
	import kpc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Poll channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_data,
	// Result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data,
	// Configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Configuration registers.
	logic [7:0]  idle_code_q;
	logic [31:0] long_ticks_q;

	// Key history.
	logic [7:0]  last_key_q;
	logic [31:0] mark_time_q;
	logic        edge_masked_q;
	logic        repeat_mode_q;

	// Input register and result register.
	logic        valid_s1;
	in_item_t    item_s1;
	logic        out_valid_q;
	out_item_t   out_item_q;

	// Next-state and result of the classification pass.
	logic        advance;
	logic [31:0] held;
	logic        key_change;
	logic [7:0]  last_key_d;
	logic [31:0] mark_time_d;
	logic        edge_masked_d;
	logic        repeat_mode_d;
	out_item_t   result;

	// The input stage moves on when the result register is empty or being taken.
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_code_q  <= IDLE_CODE_RST;
			long_ticks_q <= LONG_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IDLE_CODE:  idle_code_q  <= cfg_wdata[7:0];
				REG_LONG_TICKS: long_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Classification of the registered poll against the key history.
	always_comb begin
		held          = item_s1.time_now - mark_time_q;
		key_change    = !edge_masked_q && (item_s1.key_now != last_key_q);
		last_key_d    = item_s1.key_now;
		mark_time_d   = mark_time_q;
		edge_masked_d = edge_masked_q;
		repeat_mode_d = repeat_mode_q;
		result.key_out    = item_s1.key_now;
		result.event_kind = EV_NONE;

		if (key_change) begin
			// A new key is a press; a return to idle is a release.
			mark_time_d = item_s1.time_now;
			if (item_s1.key_now != idle_code_q) begin
				result.event_kind = EV_PRESS;
			end else begin
				result.key_out = last_key_q;
				if (repeat_mode_q || (held < long_ticks_q)) begin
					result.event_kind = EV_SHORT;
				end else begin
					result.event_kind = EV_LONG;
					repeat_mode_d     = 1'b1;
				end
			end
		end else if (item_s1.key_now != idle_code_q) begin
			// Key still held: fires a long press once the threshold is reached.
			if (repeat_mode_q || (held >= long_ticks_q)) begin
				result.event_kind = EV_LONG;
				edge_masked_d     = 1'b1;
				last_key_d        = idle_code_q;
			end
		end else begin
			// Idle poll: restart timing and clear the masks.
			result.key_out = idle_code_q;
			mark_time_d    = item_s1.time_now;
			edge_masked_d  = 1'b0;
			repeat_mode_d  = 1'b0;
		end

		result.repeat_active = repeat_mode_d;
	end

	// Key history, updated as each item moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q    <= IDLE_CODE_RST;
			mark_time_q   <= '0;
			edge_masked_q <= 1'b0;
			repeat_mode_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			last_key_q    <= last_key_d;
			mark_time_q   <= mark_time_d;
			edge_masked_q <= edge_masked_d;
			repeat_mode_q <= repeat_mode_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_item_q <= result;
		end
	end

	// The input side only stalls when a poll waits behind a blocked result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// A press never reports the idle code.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_item_q.event_kind == EV_PRESS))
		|-> (out_item_q.key_out != idle_code_q))
		else $error("press event carries the idle code");

	// A pending result reports the repeat flag the history now holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.repeat_active == repeat_mode_q))
		else $error("repeat flag out of step with the key history");

	// A long press leaves either the edge mask or the repeat mode set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_item_q.event_kind == EV_LONG))
		|-> (edge_masked_q || repeat_mode_q))
		else $error("long press left no mask and no repeat mode");

	// An idle poll clears the mask and the repeat mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_item_q.event_kind == EV_NONE)
			&& (out_item_q.key_out == idle_code_q))
		|-> (!edge_masked_q && !repeat_mode_q))
		else $error("idle poll did not clear the key history flags");

endmodule

`default_nettype wire
